// ===== hw/rtl/tss_pkg.sv =====
// Shared types and codes for the thread slot scheduler.
`timescale 1ns / 1ps

package tss_pkg;

  localparam int ACT_W      = 3;
  localparam int ADDR_W     = 32;
  localparam int SLEEP_W    = 32;
  localparam int SLOT_OUT_W = 3;

  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_KILL   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SLEEP  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SWITCH = 3'd4;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                  status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [SLOT_OUT_W-1:0] next_slot;
    logic                  any_alive;
  } tss_result_t;

endpackage

// ===== hw/rtl/tss_succ.sv =====
// Circular next-alive-slot finder: rotate, priority encode, wrap.
`timescale 1ns / 1ps

module tss_succ #(
  parameter  int SLOTS = 8,
  localparam int SW    = $clog2(SLOTS)
) (
  input  logic [SLOTS-1:0] alive,
  input  logic [SW-1:0]    cur,
  output logic [SW-1:0]    succ,
  output logic             found
);

  localparam logic [SW:0] SLOTS_W = (SW+1)'(SLOTS);

  logic [2*SLOTS-1:0] dbl;
  logic [2*SLOTS-1:0] rot_full;
  logic [SLOTS-1:0]   rot;
  logic [SW:0]        start;
  logic [SW-1:0]      ofs;
  logic [SW:0]        sum;
  logic [SW:0]        sum_wrap;

  assign dbl      = {alive, alive};
  assign start    = {1'b0, cur} + (SW+1)'(1);
  assign rot_full = dbl >> start;
  assign rot      = rot_full[SLOTS-1:0];

  // bit i of rot is slot (cur + 1 + i) mod SLOTS
  always_comb begin
    ofs = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (rot[i]) begin
        ofs = SW'(i);
      end
    end
  end

  assign sum      = start + {1'b0, ofs};
  assign sum_wrap = (sum >= SLOTS_W) ? (sum - SLOTS_W) : sum;
  assign found    = |alive;
  assign succ     = found ? sum_wrap[SW-1:0] : cur;

endmodule

// ===== hw/rtl/tss_table.sv =====
// Thread table state and combinational action execution.
`timescale 1ns / 1ps

module tss_table #(
  parameter  int SLOTS = 8,
  localparam int SW    = $clog2(SLOTS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         exec,
  input  logic [tss_pkg::ACT_W-1:0]    action,
  input  logic [tss_pkg::ADDR_W-1:0]   entry_address,
  input  logic [tss_pkg::SLEEP_W-1:0]  sleep_time,
  output tss_pkg::tss_result_t         res
);

  import tss_pkg::*;

  logic [SLOTS-1:0]   alive_r;
  logic [SLOTS-1:0]   alive_nxt;
  logic [SLEEP_W-1:0] sleep_r   [SLOTS];
  logic [SLEEP_W-1:0] sleep_nxt [SLOTS];
  logic [ADDR_W-1:0]  entry_mem [SLOTS];
  logic [SW-1:0]      running_r;
  logic [SW-1:0]      running_nxt;

  logic [SW-1:0]      pick;
  logic               free_found;
  logic               add_ok;
  logic [SW-1:0]      shown;
  logic               status;
  logic [SLEEP_W:0]   sleep_sum;
  logic [SW-1:0]      succ_now;
  logic               found_now;
  logic [SW-1:0]      succ_after;
  logic               found_after;
  logic [SW+2:0]      shown_ext;
  logic [SW+2:0]      succ_ext;

  // lowest free slot
  always_comb begin
    pick = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!alive_r[i]) begin
        pick = SW'(i);
      end
    end
  end
  assign free_found = ~&alive_r;
  assign add_ok     = (action == ACT_ADD) && free_found;

  tss_succ #(.SLOTS(SLOTS)) u_succ_now (
    .alive (alive_r),
    .cur   (running_r),
    .succ  (succ_now),
    .found (found_now)
  );

  assign sleep_sum = {1'b0, sleep_r[running_r]} + {1'b0, sleep_time};

  always_comb begin
    alive_nxt   = alive_r;
    sleep_nxt   = sleep_r;
    running_nxt = running_r;
    shown       = running_r;
    status      = STATUS_OK;
    unique case (action)
      ACT_ADD: begin
        if (free_found) begin
          alive_nxt[pick] = 1'b1;
          sleep_nxt[pick] = '0;
          shown           = pick;
        end else begin
          status = STATUS_FULL;
        end
      end
      ACT_KILL: begin
        alive_nxt[running_r] = 1'b0;
      end
      ACT_SLEEP: begin
        // saturate on carry out
        sleep_nxt[running_r] = sleep_sum[SLEEP_W] ? '1 : sleep_sum[SLEEP_W-1:0];
      end
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (sleep_r[i] != '0) begin
            sleep_nxt[i] = sleep_r[i] - SLEEP_W'(1);
          end
        end
      end
      ACT_SWITCH: begin
        // empty table: running slot stays put
        if (found_now) begin
          running_nxt = succ_now;
        end
        shown = running_nxt;
      end
      default: begin
      end
    endcase
  end

  // successor after the action, on the updated table
  tss_succ #(.SLOTS(SLOTS)) u_succ_after (
    .alive (alive_nxt),
    .cur   (running_nxt),
    .succ  (succ_after),
    .found (found_after)
  );

  assign shown_ext     = {3'b000, shown};
  assign succ_ext      = {3'b000, succ_after};
  assign res.status    = status;
  assign res.slot      = shown_ext[SLOT_OUT_W-1:0];
  assign res.next_slot = succ_ext[SLOT_OUT_W-1:0];
  assign res.any_alive = found_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r   <= '0;
      running_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        sleep_r[i] <= '0;
      end
    end else if (exec) begin
      alive_r   <= alive_nxt;
      running_r <= running_nxt;
      sleep_r   <= sleep_nxt;
    end
  end

  // entry addresses: stored only, no reset
  always_ff @(posedge clk) begin
    if (exec && add_ok) begin
      entry_mem[pick] <= entry_address;
    end
  end

endmodule

// ===== hw/rtl/thread_slot_scheduler_core.sv =====
// Top level of the round-robin thread slot scheduler.
// An accepted item moves through the input register, then the result register; while the
// result is stalled and the input stage is full, the input is held off. Throughput: one
// item per cycle while out_stall is low; the table update is a single combinational pass.
// Reset (rst_n low, synchronous): all slots dead, sleep counters zero, running slot zero,
// both pipeline stages empty. Entry addresses are not cleared.
`timescale 1ns / 1ps

module thread_slot_scheduler_core #(
  parameter int THREAD_SLOTS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tss_pkg::ACT_W-1:0]           in_action,
  input  logic [tss_pkg::ADDR_W-1:0]          in_entry_address,
  input  logic [tss_pkg::SLEEP_W-1:0]         in_sleep_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_status,
  output logic [tss_pkg::SLOT_OUT_W-1:0]      out_slot,
  output logic [tss_pkg::SLOT_OUT_W-1:0]      out_next_slot,
  output logic                                out_any_alive
);

  import tss_pkg::*;

  // input register stage
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [ACT_W-1:0]   s1_action_r;
  logic [ADDR_W-1:0]  s1_entry_r;
  logic [SLEEP_W-1:0] s1_sleep_r;

  // result register stage
  logic               out_valid_r;
  logic               out_valid_nxt;
  tss_result_t        out_res_r;
  tss_result_t        res;

  logic               out_ready;
  logic               exec;
  logic               in_acc;

  // Result slot frees up when empty or being taken this cycle.
  assign out_ready = !out_valid_r || !out_stall;
  // An item executes (and updates the table) as it moves into the result register.
  assign exec      = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (exec) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_entry_r  <= in_entry_address;
      s1_sleep_r  <= in_sleep_time;
    end
    if (exec) begin
      out_res_r <= res;
    end
  end

  // Thread table: alive bits, sleep counters, entry addresses, running slot.
  tss_table #(.SLOTS(THREAD_SLOTS)) u_table (
    .clk           (clk),
    .rst_n         (rst_n),
    .exec          (exec),
    .action        (s1_action_r),
    .entry_address (s1_entry_r),
    .sleep_time    (s1_sleep_r),
    .res           (res)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_res_r.status;
  assign out_slot      = out_res_r.slot;
  assign out_next_slot = out_res_r.next_slot;
  assign out_any_alive = out_res_r.any_alive;

`ifndef SYNTHESIS
  // An executed item always lands in the result register.
  a_exec_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("executed item did not reach result register");

  // Input is only held off by a full input stage behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without cause");

  // With no live slot, the successor falls back to the running slot.
  a_none_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.any_alive) |-> (out_res_r.next_slot == out_res_r.slot))
    else $error("next slot differs from running slot with no live thread");

  // A full table means every slot is alive.
  a_full_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == STATUS_FULL)) |-> out_res_r.any_alive)
    else $error("add reported full with no live thread");
`endif

endmodule

// ===== sim/thread_slot_scheduler_core_tb.sv =====
// Self-checking testbench for the thread slot scheduler core.
`timescale 1ns / 1ps

module thread_slot_scheduler_core_tb;
  import tss_pkg::*;

  localparam int SLOTS      = 8;
  localparam int DIR_N      = 25;
  localparam int RAND_ITEMS = 1850;

  // Action codes the block does not decode; they must leave the table alone.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pat_t;

  // One row of the directed table. has_exp marks rows whose result is typed in.
  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [ADDR_W-1:0]  addr;
    logic [SLEEP_W-1:0] amount;
    logic               has_exp;
    tss_result_t        exp;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACT_W-1:0]      in_action = '0;
  logic [ADDR_W-1:0]     in_entry_address = '0;
  logic [SLEEP_W-1:0]    in_sleep_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  logic                  out_status;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [SLOT_OUT_W-1:0] out_next_slot;
  logic                  out_any_alive;

  thread_slot_scheduler_core #(
    .THREAD_SLOTS(SLOTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_entry_address(in_entry_address),
    .in_sleep_time(in_sleep_time),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_slot(out_slot),
    .out_next_slot(out_next_slot),
    .out_any_alive(out_any_alive)
  );

  // Mirror of the thread table, advanced once per accepted item.
  logic                  slot_alive [SLOTS];
  logic [SLEEP_W-1:0]    slot_sleep [SLOTS];
  logic [ADDR_W-1:0]     slot_entry [SLOTS];
  logic [SLOT_OUT_W-1:0] run_slot;

  tss_result_t pending_results [$];   // expected results, oldest first
  dir_row_t    dir_rows [DIR_N];

  int         err_cnt = 0;
  int         items_sent = 0;
  int         results_checked = 0;
  int         full_adds = 0;
  int         act_seen [8];
  int         burst_left = 0;
  logic       hold_off = 1'b0;   // long receiver hold-off, forces back-pressure
  stall_pat_t stall_pat = STALL_NONE;
  int         pat_left = 0;
  int         rx_cycle = 0;
  logic       stall_next;
  tss_result_t seen_res;
  tss_result_t want_res;

  initial begin
    forever #5 clk = ~clk;
  end

  // Synchronous reset: held low from time zero, then released once.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout: %0d items sent, %0d results outstanding",
             items_sent, pending_results.size());
    $display("[thread_slot_scheduler_core] ERROR");
    $finish;
  end

  // First alive slot after cur in circular order; cur itself when none is alive.
  function automatic logic [SLOT_OUT_W-1:0] next_alive(input logic [SLOT_OUT_W-1:0] cur,
                                                      output logic found);
    int j;
    next_alive = cur;
    found = 1'b0;
    for (int k = 1; k <= SLOTS; k++) begin
      j = (int'(cur) + k) % SLOTS;
      if (!found && slot_alive[j]) begin
        found = 1'b1;
        next_alive = j[SLOT_OUT_W-1:0];
      end
    end
  endfunction

  // Applies one scheduler action to the mirror and returns the result it shows.
  function automatic tss_result_t schedule_action(input logic [ACT_W-1:0] act,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [SLEEP_W-1:0] amount);
    tss_result_t           r;
    logic [SLOT_OUT_W-1:0] shown;
    logic [SLEEP_W:0]      sum;
    logic                  found;
    int                    pick;
    r = '0;
    r.status = STATUS_OK;
    shown = run_slot;
    case (act)
      ACT_ADD: begin
        // lowest dead slot wins; running slot is left where it is
        pick = -1;
        for (int i = 0; i < SLOTS; i++)
          if (pick < 0 && !slot_alive[i]) pick = i;
        if (pick >= 0) begin
          slot_alive[pick] = 1'b1;
          slot_sleep[pick] = '0;
          slot_entry[pick] = addr;
          shown = pick[SLOT_OUT_W-1:0];
        end else begin
          r.status = STATUS_FULL;
        end
      end
      ACT_KILL: slot_alive[run_slot] = 1'b0;
      ACT_SLEEP: begin
        // saturating add, alive or not
        sum = {1'b0, slot_sleep[run_slot]} + amount;
        slot_sleep[run_slot] = sum[SLEEP_W] ? '1 : sum[SLEEP_W-1:0];
      end
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_sleep[i] != '0) slot_sleep[i] = slot_sleep[i] - 1'b1;
      end
      ACT_SWITCH: begin
        run_slot = next_alive(run_slot, found);
        shown = run_slot;
      end
      default: ;
    endcase
    r.slot = shown;
    r.next_slot = next_alive(run_slot, found);
    r.any_alive = found;
    return r;
  endfunction

  // Offers one item in bursts with random gaps, waits for acceptance, then
  // queues the expected result (typed-in where the row gives one).
  task automatic offer_item(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr,
                            input logic [SLEEP_W-1:0] amount, input logic has_exp,
                            input tss_result_t exp);
    tss_result_t predicted;
    int          gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      // no gaps during a hold-off, so the block really fills up
      if (gap > 0 && !hold_off) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_entry_address <= addr;
    in_sleep_time <= amount;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
    act_seen[act]++;
    predicted = schedule_action(act, addr, amount);
    if (predicted.status == STATUS_FULL) full_adds++;
    pending_results.push_back(has_exp ? exp : predicted);
  endtask

  // Stimulus: directed table, then weighted random traffic, then drain.
  initial begin
    int                 roll;
    int                 bias;
    int                 add_w;
    int                 kill_w;
    logic [ACT_W-1:0]   act;
    logic [SLEEP_W-1:0] amt;

    for (int i = 0; i < SLOTS; i++) begin
      slot_alive[i] = 1'b0;
      slot_sleep[i] = '0;
      slot_entry[i] = '0;
    end
    for (int i = 0; i < 8; i++) act_seen[i] = 0;
    run_slot = '0;

    dir_rows = '{
      // empty table: everything reports slot 0, nothing alive
      '{ACT_SWITCH,    32'h0000_0000, 32'h0000_0000, 1'b1, '{STATUS_OK, 3'd0, 3'd0, 1'b0}},
      '{ACT_KILL,      32'h0000_0000, 32'h0000_0000, 1'b1, '{STATUS_OK, 3'd0, 3'd0, 1'b0}},
      // sleep on a dead slot, then saturate and tick
      '{ACT_SLEEP,     32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 3'd0, 3'd0, 1'b0}},
      '{ACT_SLEEP,     32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{STATUS_OK, 3'd0, 3'd0, 1'b0}},
      '{ACT_TICK,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 3'd0, 3'd0, 1'b0}},
      '{ACT_SPARE_LO,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 3'd0, 3'd0, 1'b0}},
      '{ACT_SPARE_HI,  32'h0000_0000, 32'h0000_0000, 1'b1, '{STATUS_OK, 3'd0, 3'd0, 1'b0}},
      // fill the table; a lone slot is its own successor
      '{ACT_ADD,       32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{STATUS_OK, 3'd0, 3'd0, 1'b1}},
      '{ACT_ADD,       32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{STATUS_OK, 3'd1, 3'd1, 1'b1}},
      '{ACT_ADD,       32'hA5A5_5A5A, 32'h0000_0000, 1'b0, '0},
      '{ACT_ADD,       32'h5A5A_A5A5, 32'h0000_0000, 1'b0, '0},
      '{ACT_ADD,       32'h0000_FFFF, 32'h0000_0000, 1'b0, '0},
      '{ACT_ADD,       32'hFFFF_0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_ADD,       32'h1234_5678, 32'h0000_0000, 1'b0, '0},
      '{ACT_ADD,       32'h8000_0001, 32'h0000_0000, 1'b0, '0},
      // add on a full table
      '{ACT_ADD,       32'hCAFE_F00D, 32'h0000_0000, 1'b1, '{STATUS_FULL, 3'd0, 3'd1, 1'b1}},
      '{ACT_SWITCH,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_KILL,      32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      // freed slot is reused by the next add
      '{ACT_ADD,       32'hDEAD_BEEF, 32'h0000_0000, 1'b0, '0},
      '{ACT_SLEEP,     32'h0000_0000, 32'h8000_0000, 1'b0, '0},
      '{ACT_SLEEP,     32'h0000_0000, 32'h8000_0000, 1'b0, '0},
      '{ACT_TICK,      32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_SPARE_MID, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_SWITCH,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{ACT_KILL,      32'h0000_0000, 32'h0000_0000, 1'b0, '0}
    };

    wait (rst_n);
    @(posedge clk);

    foreach (dir_rows[i])
      offer_item(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].amount,
                 dir_rows[i].has_exp, dir_rows[i].exp);

    // Random traffic. The bias swings every 200 items between draining the
    // table (kill-heavy) and filling it (add-heavy), so empty, sparse and full
    // tables all see switches, kills and failed adds.
    bias = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 200 == 0) bias = $urandom_range(0, 2);
      add_w  = (bias == 0) ? 12 : (bias == 1) ? 28 : 45;
      kill_w = (bias == 0) ? 22 : (bias == 1) ? 10 : 5;
      roll = $urandom_range(0, 99);
      if (roll < add_w) act = ACT_ADD;
      else if (roll < add_w + kill_w) act = ACT_KILL;
      else if (roll < add_w + kill_w + 15) act = ACT_SLEEP;
      else if (roll < add_w + kill_w + 30) act = ACT_TICK;
      else if (roll < add_w + kill_w + 35)
        act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      else act = ACT_SWITCH;
      // sleep amounts: small, anything, or close enough to the top to saturate
      case ($urandom_range(0, 2))
        0: amt = $urandom_range(0, 15);
        1: amt = $urandom;
        default: amt = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      endcase
      offer_item(act, $urandom, amt, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then allow for the two-stage pipe to settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d items (%0d add, %0d of them on a full table, %0d kill, %0d sleep,",
             items_sent, act_seen[ACT_ADD], full_adds, act_seen[ACT_KILL],
             act_seen[ACT_SLEEP]);
    $display("     %0d tick, %0d switch, %0d unused codes), %0d results checked, %0d errors",
             act_seen[ACT_TICK], act_seen[ACT_SWITCH],
             act_seen[ACT_SPARE_LO] + act_seen[ACT_SPARE_MID] + act_seen[ACT_SPARE_HI],
             results_checked, err_cnt);
    if (err_cnt == 0)
      $display("[thread_slot_scheduler_core] OK");
    else
      $display("[thread_slot_scheduler_core] ERROR");
    $finish;
  end

  // Two long hold-offs on the result side while the sender keeps offering.
  initial begin
    for (int h = 1; h <= 2; h++) begin
      wait (items_sent >= h * 700);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (120) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // Result side: checks every accepted item against the oldest expectation,
  // then picks the next stall value from its own pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_res = '{out_status, out_slot, out_next_slot, out_any_alive};
      results_checked++;
      if (pending_results.size() == 0) begin
        if (err_cnt < 10)
          $display("%0t: result with nothing pending: status %0b slot %0d next %0d alive %0b",
                   $realtime, seen_res.status, seen_res.slot, seen_res.next_slot,
                   seen_res.any_alive);
        err_cnt++;
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res.status !== want_res.status || seen_res.slot !== want_res.slot ||
            seen_res.next_slot !== want_res.next_slot ||
            seen_res.any_alive !== want_res.any_alive) begin
          if (err_cnt < 10)
            $display("%0t: result %0d exp st/sl/nx/al %0b/%0d/%0d/%0b got %0b/%0d/%0d/%0b",
                     $realtime, results_checked, want_res.status, want_res.slot,
                     want_res.next_slot, want_res.any_alive, seen_res.status,
                     seen_res.slot, seen_res.next_slot, seen_res.any_alive);
          err_cnt++;
        end
      end
    end

    rx_cycle++;
    if (pat_left == 0) begin
      stall_pat = stall_pat_t'($urandom_range(0, 3));
      pat_left = $urandom_range(64, 256);
    end
    pat_left--;
    case (stall_pat)
      STALL_NONE:  stall_next = 1'b0;
      STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: stall_next = ($urandom_range(0, 9) < 7);
      default:     stall_next = ((rx_cycle % 7) < 3);
    endcase
    out_stall <= hold_off || stall_next;
  end

endmodule
